[hdl/sab_pkg.sv]
// Shared types and constants for the suffix automaton builder.
// No dependencies; sab_ctrl, sab_dp and the top level import this package.
package sab_pkg;

  // Default sizes of the automaton.
  localparam int MaxStatesDef = 8192;
  localparam int AlphabetDef  = 26;

  // Fixed widths of the beat fields.
  localparam int SymW = 5;
  localparam int OutW = 13;

  // Input beat.
  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            restart;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [OutW-1:0] new_state;
    logic [OutW-1:0] link_state;
    logic [OutW-1:0] state_length;
    logic            cloned;
    logic [OutW-1:0] clone_index;
    logic [OutW-1:0] distinct_added;
    logic            overflow;
  } out_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE, S_RST, S_ZROOT, S_CHECK, S_ZNEW, S_W1, S_W2, S_Q, S_CP, S_FIX,
    S_V1, S_V2, S_FIN
  } state_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RST, OP_ZROOT, OP_BAD, OP_OVF, OP_START, OP_ZNEW,
    OP_W1, OP_W2, OP_Q, OP_CP, OP_FIX, OP_V1, OP_V2, OP_FIN
  } op_t;

  // Command from controller to datapath.
  typedef struct packed {
    op_t op;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic sym_bad;
    logic ovf;
    logic p_zero;
    logic go_zero;
    logic go_eq_q;
    logic len_match;
    logic k_zlast;
    logic k_end;
  } stat_t;

endpackage

[hdl/suffix_automaton_builder.sv]
// Top level of the suffix automaton builder: controller plus datapath.
// Depends on sab_pkg, sab_ctrl and sab_dp.
//
//   channel  | handshake       | beat
//   ---------+-----------------+----------------------------------
//   input    | start, busy     | in_data  (symbol, restart)
//   result   | out_valid       | out_data (new state, link, ...)
//
// A letter is accepted only while busy is low. Each letter clears the row of the
// new state and walks the suffix links; a clone also copies the row, fixes the
// links and redirects the transitions that pointed at the cloned state.
// The walks read the transition memory at each suffix-link step.
// After reset, and on a restart, the root row is cleared while busy stays high.
// A refused letter is answered with a result beat. A result is strobed for one
// cycle by out_valid; the receiver cannot stall it.
module suffix_automaton_builder
  import sab_pkg::*;
#(
  parameter int MAX_STATES = MaxStatesDef,
  parameter int ALPHABET   = AlphabetDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  sab_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .restart(in_data.restart),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  sab_dp #(.MAX_STATES(MAX_STATES), .ALPHABET(ALPHABET)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule

[hdl/sab_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sab_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/sab_ctrl.sv]
// Controller state machine of the suffix automaton builder.
// Depends on sab_pkg; drives sab_dp through cmd_t and reads stat_t.
module sab_ctrl
  import sab_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  restart,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;

  // State register; reset begins with the root row clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd.op    = OP_NONE;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op    = OP_LOAD;
          pend_nxt  = 1'b1;
          state_nxt = restart ? S_RST : S_CHECK;
        end
      end
      S_RST: begin
        cmd.op    = OP_RST;
        state_nxt = S_ZROOT;
      end
      S_ZROOT: begin
        cmd.op = OP_ZROOT;
        if (stat.k_zlast) begin
          state_nxt = pend_r ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        if (stat.sym_bad) begin
          cmd.op    = OP_BAD;
          state_nxt = S_IDLE;
        end else if (stat.ovf) begin
          cmd.op    = OP_OVF;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_START;
          state_nxt = S_ZNEW;
        end
      end
      S_ZNEW: begin
        cmd.op = OP_ZNEW;
        if (stat.k_zlast) begin
          state_nxt = S_W1;
        end
      end
      S_W1: begin
        cmd.op    = OP_W1;
        state_nxt = stat.p_zero ? S_FIN : S_W2;
      end
      S_W2: begin
        cmd.op    = OP_W2;
        state_nxt = stat.go_zero ? S_W1 : S_Q;
      end
      S_Q: begin
        cmd.op    = OP_Q;
        state_nxt = stat.len_match ? S_FIN : S_CP;
      end
      S_CP: begin
        cmd.op = OP_CP;
        if (stat.k_end) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.op    = OP_FIX;
        state_nxt = S_V1;
      end
      S_V1: begin
        cmd.op    = OP_V1;
        state_nxt = stat.p_zero ? S_FIN : S_V2;
      end
      S_V2: begin
        cmd.op    = OP_V2;
        state_nxt = stat.go_eq_q ? S_V1 : S_FIN;
      end
      S_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/sab_dp.sv]
// Datapath of the suffix automaton builder: state memories, walk registers
// and the result register. Depends on sab_pkg and sab_ram.
module sab_dp
  import sab_pkg::*;
#(
  parameter int MAX_STATES = MaxStatesDef,
  parameter int ALPHABET   = AlphabetDef
) (
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   in_data,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  out_valid,
  output out_t  out_data
);

  localparam int SW = $clog2(MAX_STATES);
  localparam int CW = $clog2(ALPHABET);
  localparam int KW = $clog2(ALPHABET + 1);
  localparam int TDEPTH = MAX_STATES << CW;
  localparam int TAW = SW + CW;

  logic [SymW-1:0] c_r;
  logic [SW-1:0]   last_r, count_r, p_r, q_r, np_r, nq_r, link_np_r;
  logic [SW-1:0]   lenp_r, len_np_r, len_link_r;
  logic            first_r, cloned_r;
  logic [KW-1:0]   k_r;
  logic            out_valid_r;
  out_t            out_r;

  logic [CW-1:0]   col;
  logic [CW-1:0]   kcol;
  logic [CW-1:0]   kcol_prev;
  logic [SW-1:0]   trans_rd, link_rd, len_rd;
  logic            t_we, l_we, n_we;
  logic [TAW-1:0]  t_waddr, t_raddr;
  logic [SW-1:0]   t_wdata, l_waddr, l_wdata, l_raddr, n_waddr, n_wdata, n_raddr;
  logic [SW:0]     count_plus2;

  assign col       = CW'(c_r);
  assign kcol      = CW'(k_r);
  assign kcol_prev = CW'(k_r - 1'b1);
  assign count_plus2 = {1'b0, count_r} + (SW+1)'(2);

  // Status toward the controller.
  always_comb begin
    stat.sym_bad   = ({4'b0, c_r} >= 9'(ALPHABET));
    stat.ovf       = (count_plus2 > (SW+1)'(MAX_STATES - 1));
    stat.p_zero    = (p_r == '0);
    stat.go_zero   = (trans_rd == '0);
    stat.go_eq_q   = (trans_rd == q_r);
    stat.len_match = (len_rd == lenp_r + 1'b1);
    stat.k_zlast   = (k_r == KW'(ALPHABET - 1));
    stat.k_end     = (k_r == KW'(ALPHABET));
  end

  // Memory ports, chosen by the current operation.
  always_comb begin
    t_we    = 1'b0;
    t_waddr = {p_r, col};
    t_wdata = np_r;
    t_raddr = {p_r, col};
    l_we    = 1'b0;
    l_waddr = np_r;
    l_wdata = link_np_r;
    l_raddr = p_r;
    n_we    = 1'b0;
    n_waddr = np_r;
    n_wdata = len_np_r;
    n_raddr = p_r;
    case (cmd.op)
      OP_RST: begin
        l_we    = 1'b1;
        l_waddr = SW'(1);
        l_wdata = '0;
        n_we    = 1'b1;
        n_waddr = SW'(1);
        n_wdata = '0;
      end
      OP_ZROOT: begin
        t_we    = 1'b1;
        t_waddr = {SW'(1), kcol};
        t_wdata = '0;
      end
      OP_ZNEW: begin
        t_we    = 1'b1;
        t_waddr = {np_r, kcol};
        t_wdata = '0;
      end
      OP_W2: begin
        t_we    = stat.go_zero;
        l_raddr = trans_rd;
        n_raddr = trans_rd;
      end
      OP_Q: begin
        l_we    = !stat.len_match;
        l_waddr = count_r + 1'b1;
        l_wdata = link_rd;
      end
      OP_CP: begin
        t_raddr = {q_r, kcol};
        t_we    = (k_r != '0);
        t_waddr = {nq_r, kcol_prev};
        t_wdata = trans_rd;
      end
      OP_FIX: begin
        n_we    = 1'b1;
        n_waddr = nq_r;
        n_wdata = lenp_r + 1'b1;
        l_we    = 1'b1;
        l_waddr = q_r;
        l_wdata = nq_r;
      end
      OP_V2: begin
        t_we    = stat.go_eq_q;
        t_wdata = nq_r;
      end
      OP_FIN: begin
        l_we = 1'b1;
        n_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  sab_ram #(.WIDTH(SW), .DEPTH(TDEPTH)) u_trans (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(trans_rd)
  );

  sab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_link (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(link_rd)
  );

  sab_ram #(.WIDTH(SW), .DEPTH(MAX_STATES)) u_len (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(len_rd)
  );

  // Control registers: automaton size, last state, column counter and the result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= SW'(1);
      count_r     <= SW'(1);
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (cmd.op)
        OP_RST: begin
          last_r  <= SW'(1);
          count_r <= SW'(1);
          k_r     <= '0;
        end
        OP_ZROOT, OP_ZNEW, OP_CP: begin
          k_r <= k_r + 1'b1;
        end
        OP_START: begin
          count_r <= count_r + 1'b1;
          last_r  <= count_r + 1'b1;
          k_r     <= '0;
        end
        OP_Q: begin
          if (!stat.len_match) begin
            count_r <= count_r + 1'b1;
            k_r     <= '0;
          end
        end
        OP_BAD, OP_OVF, OP_FIN: begin
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Walk and result payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        c_r <= in_data.symbol;
      end
      OP_BAD: begin
        out_r <= '0;
      end
      OP_OVF: begin
        out_r          <= '0;
        out_r.overflow <= 1'b1;
      end
      OP_START: begin
        np_r     <= count_r + 1'b1;
        p_r      <= last_r;
        nq_r     <= '0;
        cloned_r <= 1'b0;
        first_r  <= 1'b1;
      end
      OP_W1: begin
        if (stat.p_zero) begin
          link_np_r  <= SW'(1);
          len_link_r <= '0;
        end
      end
      OP_W2: begin
        if (first_r) begin
          len_np_r <= len_rd + 1'b1;
        end
        first_r <= 1'b0;
        if (stat.go_zero) begin
          p_r <= link_rd;
        end else begin
          q_r    <= trans_rd;
          lenp_r <= len_rd;
        end
      end
      OP_Q: begin
        if (stat.len_match) begin
          link_np_r  <= q_r;
          len_link_r <= len_rd;
        end else begin
          nq_r     <= count_r + 1'b1;
          cloned_r <= 1'b1;
        end
      end
      OP_FIX: begin
        link_np_r  <= nq_r;
        len_link_r <= lenp_r + 1'b1;
      end
      OP_V2: begin
        if (stat.go_eq_q) begin
          p_r <= link_rd;
        end
      end
      OP_FIN: begin
        out_r.new_state      <= OutW'(np_r);
        out_r.link_state     <= OutW'(link_np_r);
        out_r.state_length   <= OutW'(len_np_r);
        out_r.cloned         <= cloned_r;
        out_r.clone_index    <= OutW'(nq_r);
        out_r.distinct_added <= OutW'(len_np_r - len_link_r);
        out_r.overflow       <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // A result beat lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held for two cycles");

  // No clone index is reported without a clone.
  a_clone_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.cloned) |-> (out_data.clone_index == '0))
    else $error("clone index without clone");

  // An overflow beat carries nothing else.
  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |-> (out_data.new_state == '0))
    else $error("overflow beat with a new state");

  // The state count stays inside the memories.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SW'(MAX_STATES - 1)) else $error("state count beyond capacity");
`endif

endmodule
